>>> hdl/afuc_pkg.sv
// afuc_pkg: shared types and constants for the audio feature unit control block
// request and selector codes, volume mapping constants, item and result structs
// no dependencies
package afuc_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 2;

  localparam logic [7:0] REQ_SET_CUR = 8'h01;
  localparam logic [7:0] REQ_GET_CUR = 8'h81;
  localparam logic [7:0] REQ_GET_MIN = 8'h82;
  localparam logic [7:0] REQ_GET_MAX = 8'h83;
  localparam logic [7:0] REQ_GET_RES = 8'h84;

  localparam logic [7:0] SEL_MUTE   = 8'h01;
  localparam logic [7:0] SEL_VOLUME = 8'h02;

  localparam logic [15:0] ENTITY_ID = 16'h0200;

  localparam logic [7:0] VOL_RESET = 8'd240;

  // dB code range: level 0..255 maps onto 0x8000..0x0800
  localparam logic [15:0] CODE_BASE  = 16'h8000;
  localparam logic [15:0] CODE_SPAN  = 16'h8800;
  localparam logic [15:0] CODE_ROUND = 16'h4400;
  localparam logic [15:0] CODE_MIN   = 16'h8001;
  localparam logic [15:0] CODE_MAX   = 16'h0800;
  localparam logic [15:0] CODE_RES   = 16'h0088;

  // span / 256, so span * v / 255 = SPAN_HI * v + SPAN_HI * v / 255
  localparam logic [7:0] SPAN_HI = 8'(CODE_SPAN >> 8);

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_BYTE = 2'd1;
  localparam logic [1:0] LEN_WORD = 2'd2;

  typedef struct packed {
    logic [15:0] write_value;
    logic [15:0] interface_entity;
    logic [15:0] control_value;
    logic [7:0]  request_code;
  } item_t;

  typedef struct packed {
    logic [7:0]  right_level;
    logic [7:0]  left_level;
    logic        mute_level;
    logic        levels_changed;
    logic [15:0] reply_value;
    logic [1:0]  reply_length;
    logic        stall_res;
  } result_t;

endpackage

>>> hdl/afuc_conv.sv
// afuc_conv: volume level <-> 16-bit dB code mapping, purely combinational
// divisions by 255 and 0x8800 done by shifts and a reciprocal multiply
// depends on afuc_pkg
module afuc_conv
  import afuc_pkg::*;
(
  input  logic [7:0]  level_in,
  output logic [15:0] code_out,
  input  logic [15:0] code_in,
  output logic [7:0]  level_out
);

  // level to code
  logic [15:0] lin;
  logic [15:0] y;
  logic [16:0] qsum;
  logic [15:0] q;

  // code to level
  logic [15:0] d;
  logic [23:0] x;
  logic [15:0] t;
  logic [13:0] u1;
  logic [25:0] prod;

  always_comb begin
    lin  = 16'(level_in) * 16'(SPAN_HI);
    y    = lin + 16'd127;
    // exact y / 255 for y below 65535
    qsum = 17'(y) + 17'(y[15:8]) + 17'd1;
    q    = 16'(qsum[16:8]);
    code_out = lin + q + CODE_BASE;
  end

  always_comb begin
    d    = code_in - CODE_BASE;
    x    = {d, 8'b0} - 24'(d) + 24'(CODE_ROUND);
    t    = x[23:8];
    // t / 136 as (t >> 3) / 17, reciprocal of 17 with +1 correction
    u1   = 14'(t[15:3]) + 14'd1;
    prod = 26'(u1) * 26'd3855;
    if (t >= {SPAN_HI, 8'b0}) begin
      level_out = 8'hff;
    end else begin
      level_out = prod[23:16];
    end
  end

endmodule

>>> hdl/afuc_core.sv
// afuc_core: request decode, mute and channel volume registers, reply build
// result is combinational from the staged item; state updates on fire
// depends on afuc_pkg and afuc_conv
module afuc_core
  import afuc_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic             mute_bit;
  logic             mute_next;
  logic [7:0]       channel_volume [NUM_CHANNELS];
  logic [7:0]       volume_next    [NUM_CHANNELS];

  logic [7:0]       sel;
  logic [7:0]       ch;
  logic             ch_ok;
  logic [7:0]       cur_level;
  logic [15:0]      cur_code;
  logic [7:0]       new_level;
  logic             vol_write;

  assign sel   = item.control_value[15:8];
  assign ch    = item.control_value[7:0] - 8'd1;
  assign ch_ok = 32'(ch) < NUM_CHANNELS;

  // select the addressed channel
  always_comb begin
    cur_level = '0;
    for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
      if (ch == 8'(i)) begin
        cur_level = channel_volume[i];
      end
    end
  end

  afuc_conv u_conv (
    .level_in  (cur_level),
    .code_out  (cur_code),
    .code_in   (item.write_value),
    .level_out (new_level)
  );

  always_comb begin
    res.stall_res      = 1'b1;
    res.reply_length   = LEN_NONE;
    res.reply_value    = '0;
    res.levels_changed = 1'b0;
    mute_next          = mute_bit;
    vol_write          = 1'b0;

    if (item.interface_entity == ENTITY_ID) begin
      if (sel == SEL_MUTE) begin
        if (item.request_code == REQ_GET_CUR) begin
          res.stall_res    = 1'b0;
          res.reply_length = LEN_BYTE;
          res.reply_value  = 16'(mute_bit);
        end else if (item.request_code == REQ_SET_CUR) begin
          mute_next          = item.write_value[0];
          res.stall_res      = 1'b0;
          res.levels_changed = 1'b1;
        end
      end else if (sel == SEL_VOLUME && ch_ok) begin
        case (item.request_code)
          REQ_GET_CUR: begin
            res.stall_res    = 1'b0;
            res.reply_length = LEN_WORD;
            res.reply_value  = cur_code;
          end
          REQ_GET_MIN: begin
            res.stall_res    = 1'b0;
            res.reply_length = LEN_WORD;
            res.reply_value  = CODE_MIN;
          end
          REQ_GET_MAX: begin
            res.stall_res    = 1'b0;
            res.reply_length = LEN_WORD;
            res.reply_value  = CODE_MAX;
          end
          REQ_GET_RES: begin
            res.stall_res    = 1'b0;
            res.reply_length = LEN_WORD;
            res.reply_value  = CODE_RES;
          end
          REQ_SET_CUR: begin
            vol_write          = 1'b1;
            res.stall_res      = 1'b0;
            res.levels_changed = 1'b1;
          end
          default: begin
            res.stall_res = 1'b1;
          end
        endcase
      end
    end

    for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
      volume_next[i] = (vol_write && ch == 8'(i)) ? new_level : channel_volume[i];
    end

    // reported levels are the state after this request
    res.mute_level = mute_next;
    res.left_level = volume_next[0];
    if (NUM_CHANNELS > 1) begin
      res.right_level = volume_next[NUM_CHANNELS > 1 ? 1 : 0];
    end else begin
      res.right_level = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_bit <= 1'b0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        channel_volume[i] <= VOL_RESET;
      end
    end else if (fire) begin
      mute_bit <= mute_next;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        channel_volume[i] <= volume_next[i];
      end
    end
  end

endmodule

>>> hdl/audio_feature_unit_control_core.sv
// audio feature unit control: mute and per-channel volume for class requests
// Input channel s_*: one control request per item. s_tdata from bit 0 up:
//   request_code[7:0], control_value[23:8], interface_entity[39:24],
//   write_value[55:40].
// Output channel m_*: one result per request. m_tdata from bit 0 up:
//   stall_res[0], reply_length[2:1], reply_value[18:3], levels_changed[19],
//   mute_level[20], left_level[28:21], right_level[36:29], zero to bit 39.
// An accepted item waits in the input register until the output register
// is empty or being taken; it is then decoded and applied to the mute and
// volume registers, and its result is loaded into the output register.
// Throughput is one item per cycle while m_tready is high.
// When the receiver stalls, the result waits in the output register and
// one more item is still taken into the input register; then s_tready
// drops until the result is taken. Requests apply in order, so a get
// right after a set sees the new level.
// Reset (rst, synchronous, active high) empties both registers, clears
// mute and sets each channel volume to 240.
// depends on afuc_pkg, afuc_core, afuc_conv
module audio_feature_unit_control_core
  import afuc_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // request_code, control_value, interface_entity, write_value
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // stall_res, reply_length, reply_value, levels_changed, mute_level,
  // left_level, right_level, zero fill
  output logic [39:0] m_tdata
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    advance;
  logic    fire;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  afuc_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= item_t'(s_tdata);
    end
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res};

endmodule
